[sv/bfsk_pkg.sv]
// Shared types and constants for the BFSK tone burst generator.
package bfsk_pkg;

    localparam int RELOAD_W   = 24;
    localparam int TOGGLE_W   = 16;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RELOAD_ZERO  = 2'd0,
        CFG_RELOAD_ONE   = 2'd1,
        CFG_TOGGLES_ZERO = 2'd2,
        CFG_TOGGLES_ONE  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_TICK  = 1'b1
    } t_req_type;

    typedef struct packed {
        logic req_type;
        logic bit_value;
    } t_in_req;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic busy_res;
    } t_out_res;

    typedef struct packed {
        logic [RELOAD_W-1:0] reload_zero;
        logic [RELOAD_W-1:0] reload_one;
        logic [TOGGLE_W-1:0] toggles_zero;
        logic [TOGGLE_W-1:0] toggles_one;
    } t_cfg;

endpackage

[sv/bfsk_cfg.sv]
// Configuration register bank for the BFSK tone burst generator.
module bfsk_cfg
    import bfsk_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reload_zero  <= RELOAD_W'(599);
            r_cfg.reload_one   <= RELOAD_W'(499);
            r_cfg.toggles_zero <= TOGGLE_W'(20);
            r_cfg.toggles_one  <= TOGGLE_W'(24);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RELOAD_ZERO:  r_cfg.reload_zero  <= i_cfg_data[RELOAD_W-1:0];
                CFG_RELOAD_ONE:   r_cfg.reload_one   <= i_cfg_data[RELOAD_W-1:0];
                CFG_TOGGLES_ZERO: r_cfg.toggles_zero <= i_cfg_data[TOGGLE_W-1:0];
                CFG_TOGGLES_ONE:  r_cfg.toggles_one  <= i_cfg_data[TOGGLE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/bfsk_core.sv]
// Burst state: half-period timer, toggle counter and pin levels.
module bfsk_core
    import bfsk_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_req  i_req,
    input  t_cfg     i_cfg,
    output t_out_res o_res
);

    logic                r_active, n_active;
    logic [RELOAD_W-1:0] r_period_left, n_period_left;
    logic [RELOAD_W-1:0] r_period_reload, n_period_reload;
    logic [TOGGLE_W-1:0] r_toggles_left, n_toggles_left;
    logic                r_level_a, n_level_a;
    logic                r_level_b, n_level_b;

    logic [RELOAD_W-1:0] sel_reload;
    logic [TOGGLE_W-1:0] sel_toggles;

    assign sel_reload  = i_req.bit_value ? i_cfg.reload_one  : i_cfg.reload_zero;
    assign sel_toggles = i_req.bit_value ? i_cfg.toggles_one : i_cfg.toggles_zero;

    always_comb begin
        n_active        = r_active;
        n_period_left   = r_period_left;
        n_period_reload = r_period_reload;
        n_toggles_left  = r_toggles_left;
        n_level_a       = r_level_a;
        n_level_b       = r_level_b;
        if (i_accept) begin
            if (i_req.req_type == REQ_START) begin
                // restart: reload counters, keep pin levels
                n_period_reload = sel_reload;
                n_period_left   = sel_reload;
                n_toggles_left  = sel_toggles;
                n_active        = 1'b1;
            end else if (r_active) begin
                if (r_period_left == '0) begin
                    n_period_left = r_period_reload;
                    if (r_toggles_left != '0) begin
                        n_level_a      = ~r_level_a;
                        n_level_b      = r_level_a;
                        n_toggles_left = r_toggles_left - {{(TOGGLE_W-1){1'b0}}, 1'b1};
                    end else begin
                        // burst over: drop both pins
                        n_level_a = 1'b0;
                        n_level_b = 1'b0;
                        n_active  = 1'b0;
                    end
                end else begin
                    n_period_left = r_period_left - {{(RELOAD_W-1){1'b0}}, 1'b1};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active        <= 1'b0;
            r_period_left   <= '0;
            r_period_reload <= '0;
            r_toggles_left  <= '0;
            r_level_a       <= 1'b0;
            r_level_b       <= 1'b0;
        end else begin
            r_active        <= n_active;
            r_period_left   <= n_period_left;
            r_period_reload <= n_period_reload;
            r_toggles_left  <= n_toggles_left;
            r_level_a       <= n_level_a;
            r_level_b       <= n_level_b;
        end
    end

    // result reflects the state after this request
    assign o_res.pin_a    = n_level_a;
    assign o_res.pin_b    = n_level_b;
    assign o_res.busy_res = n_active;

endmodule

[sv/bfsk_out_reg.sv]
// Output result register with valid/ready handshake.
module bfsk_out_reg
    import bfsk_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_out_res i_res,
    input  logic     i_out_ready,
    output logic     o_free,
    output logic     o_out_valid,
    output t_out_res o_out_res
);

    logic     r_valid;
    t_out_res r_res;

    // free when empty or draining this cycle
    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_res   = r_res;

endmodule

[sv/bfsk_tone_burst_generator_top.sv]
// Result: the result of an accepted request is registered and shown in the cycle after it is accepted.
// Throughput: one request per cycle; the output register frees as it drains, so a
// waiting result does not block the next request unless the consumer stalls.
// Reset: synchronous, active low; clears burst state, pins low, config to defaults.
module bfsk_tone_burst_generator_top
    import bfsk_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_req               i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_res              o_out_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     cfg;
    t_out_res res;
    logic     accept;
    logic     free;

    assign o_in_ready = free;
    assign accept     = i_in_valid && free;

    bfsk_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bfsk_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_in_req),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    bfsk_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

endmodule

[sv/bfsk_checker.sv]
// Port-level checks for the BFSK tone burst generator, bound to the top level.
module bfsk_checker
    import bfsk_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_out_res o_out_res
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_res)))
        else $error("stalled result changed or dropped");

    // an accepted request yields a result on the next cycle
    a_req_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted request gave no result");

    // idle means both pins low
    a_idle_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_res.busy_res) |-> (!o_out_res.pin_a && !o_out_res.pin_b))
        else $error("pins driven while idle");

    // pins never both high
    a_pins_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_res.pin_a && o_out_res.pin_b))
        else $error("both drive pins high");

endmodule

bind bfsk_tone_burst_generator_top bfsk_checker u_bfsk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_res   (o_out_res)
);
